[src/assert_macros.svh]
// assertion macros shared by the histogram rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define RLH_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("rlh assertion failed");

// clocked check that also covers the reset cycles
`define RLH_ASSERT_NR(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("rlh assertion failed");

`endif

[src/rlh_pkg.sv]
// types and constants of the request latency histogram
`default_nettype none

package rlh_pkg;

    localparam int TAG_W     = 8;
    localparam int TIME_W    = 64;
    localparam int SEL_W     = 5;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int BIN_IDX_W = 5;
    localparam int LAT_W     = 55;
    localparam int CNT_W     = 32;

    localparam int S_DATA_W  = 80;
    localparam int M_DATA_W  = 96;
    localparam int M_PAD_W   = M_DATA_W - (BIN_IDX_W + LAT_W + CNT_W);

    localparam int NS_PER_US = 1000;
    localparam int REM_W     = $clog2(NS_PER_US);
    localparam int DIGIT_W   = 16;
    localparam int DIGIT_N   = TIME_W / DIGIT_W;
    localparam int PART_W    = REM_W + DIGIT_W;
    // reciprocal of 1000 scaled by 2^RECIP_SHIFT, rounded up
    localparam int RECIP_SHIFT = PART_W + REM_W;
    localparam longint NS_RECIP =
        ((longint'(1) << RECIP_SHIFT) + longint'(NS_PER_US) - 1) / longint'(NS_PER_US);
    localparam int RECIP_W   = $clog2(NS_RECIP + 1);
    localparam int PROD_W    = PART_W + RECIP_W;
    localparam int LOG_W     = $clog2(TIME_W);

    typedef enum logic [REQ_W-1:0] {
        REQ_ISSUE    = 2'd0,
        REQ_COMPLETE = 2'd1,
        REQ_READ     = 2'd2
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_ISSUED  = 2'd0,
        STATUS_COUNTED = 2'd1,
        STATUS_IGNORED = 2'd2,
        STATUS_READ    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_TAG_WAIT,
        S_DIV,
        S_HIST_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [LAT_W-1:0] quotient;
        logic [LOG_W-1:0] log2;
    } div_res_t;

endpackage

`default_nettype wire

[src/rlh_ram.sv]
// generic simple dual-port ram with registered read
`default_nettype none

module rlh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/rlh_udiv.sv]
// divide by 1000 over 16-bit digits by reciprocal multiplication, then floor log2
`default_nettype none
`include "assert_macros.svh"

module rlh_udiv (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [rlh_pkg::TIME_W-1:0]  dividend,
    output      logic                        done,
    output      rlh_pkg::div_res_t           res
);
    import rlh_pkg::*;

    localparam int DIG_CW = $clog2(DIGIT_N);

    logic               busy_reg, busy_next;
    logic               reduce_reg, reduce_next;
    logic               fin_reg, fin_next;
    logic               done_reg, done_next;
    logic [DIG_CW-1:0]  digit_reg, digit_next;
    logic [PART_W-1:0]  part_reg, part_next;
    logic [TIME_W-1:0]  src_reg, src_next;
    logic [DIGIT_W-1:0] qdig_reg, qdig_next;
    logic [LAT_W-1:0]   quot_reg, quot_next;
    logic [LOG_W-1:0]   log_reg, log_next;

    logic [PROD_W-1:0]  prod;
    logic [REM_W-1:0]   part_rem;
    logic [LOG_W-1:0]   lead;

    // quotient digit estimate, exact for every partial dividend below 1000 * 2^16
    assign prod     = PROD_W'(part_reg) * PROD_W'(NS_RECIP);
    assign part_rem = REM_W'(part_reg - PART_W'(qdig_reg) * PART_W'(NS_PER_US));

    // leading one of the quotient, zero maps to zero
    always_comb begin
        lead = '0;
        for (int b = 1; b < LAT_W; b++) begin
            if (quot_reg[b]) begin
                lead = LOG_W'(b);
            end
        end
    end

    always_comb begin
        busy_next   = busy_reg;
        reduce_next = reduce_reg;
        fin_next    = 1'b0;
        done_next   = 1'b0;
        digit_next  = digit_reg;
        part_next   = part_reg;
        src_next    = src_reg;
        qdig_next   = qdig_reg;
        quot_next   = quot_reg;
        log_next    = log_reg;
        if (start) begin
            busy_next   = 1'b1;
            reduce_next = 1'b0;
            digit_next  = '0;
            part_next   = {{REM_W{1'b0}}, dividend[TIME_W-1 -: DIGIT_W]};
            src_next    = {dividend[TIME_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            quot_next   = '0;
        end else if (busy_reg && !reduce_reg) begin
            qdig_next   = DIGIT_W'(prod >> RECIP_SHIFT);
            reduce_next = 1'b1;
        end else if (busy_reg) begin
            quot_next   = {quot_reg[LAT_W-DIGIT_W-1:0], qdig_reg};
            part_next   = {part_rem, src_reg[TIME_W-1 -: DIGIT_W]};
            src_next    = src_reg << DIGIT_W;
            reduce_next = 1'b0;
            digit_next  = digit_reg + 1'b1;
            if (digit_reg == DIG_CW'(DIGIT_N - 1)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            log_next  = lead;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            busy_reg   <= 1'b0;
            reduce_reg <= 1'b0;
            fin_reg    <= 1'b0;
            done_reg   <= 1'b0;
            digit_reg  <= '0;
        end else begin
            busy_reg   <= busy_next;
            reduce_reg <= reduce_next;
            fin_reg    <= fin_next;
            done_reg   <= done_next;
            digit_reg  <= digit_next;
        end
    end

    always_ff @(posedge clk) begin
        part_reg <= part_next;
        src_reg  <= src_next;
        qdig_reg <= qdig_next;
        quot_reg <= quot_next;
        log_reg  <= log_next;
    end

    assign done = done_reg;
    assign res  = '{quotient: quot_reg, log2: log_reg};

    `RLH_ASSERT(a_start_idle, clk, rst_n, start |-> (!busy_reg && !fin_reg))
    `RLH_ASSERT(a_rem_range, clk, rst_n, (busy_reg && reduce_reg) |-> (part_rem < REM_W'(NS_PER_US)))
    `RLH_ASSERT(a_done_after_fin, clk, rst_n, fin_reg |=> done_reg)
    `RLH_ASSERT(a_done_not_busy, clk, rst_n, done_reg |-> !busy_reg)

endmodule

`default_nettype wire

[src/request_latency_log2_histogram.sv]
// top level of the tagged request latency log2 histogram
`default_nettype none
`include "assert_macros.svh"

// Tracks request issue times per tag and builds a log2 histogram of completion
// latency in microseconds. One item is in work at a time; the result waits in
// an output register, so the next item is taken while it is still unread.
// A counted completion waits on the divide-by-1000 unit, which takes the
// 64-bit elapsed time as four 16-bit digits, each in a reciprocal multiply
// step and then a remainder step, and ends with a step for the log2. Tag
// table and histogram live in simple dual-port rams with registered read.
// After reset a clearing pass over max(TAG_COUNT, BIN_COUNT) addresses
// zeroes the tag valid bits and the bin counters; no item is taken during
// it. Request type 3 is accepted and gives no result.

module request_latency_log2_histogram #(
    parameter int TAG_COUNT = 256,
    parameter int BIN_COUNT = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // request_tag, now_ns, bin_select
    input  wire logic [rlh_pkg::S_DATA_W-1:0]    s_tdata,
    // req_type
    input  wire logic [rlh_pkg::REQ_W-1:0]       s_tuser,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // bin_index, latency_us, bin_count
    output      logic [rlh_pkg::M_DATA_W-1:0]    m_tdata,
    // status
    output      logic [rlh_pkg::STATUS_W-1:0]    m_tuser
);
    import rlh_pkg::*;

    localparam int TW    = $clog2(TAG_COUNT);
    localparam int BW    = $clog2(BIN_COUNT);
    localparam int CLR_N = (TAG_COUNT > BIN_COUNT) ? TAG_COUNT : BIN_COUNT;
    localparam int CW    = $clog2(CLR_N);

    // request_tag modulo TAG_COUNT, one restoring step per tag bit
    function automatic logic [TW-1:0] tag_index(input logic [TAG_W-1:0] tag);
        logic [TW:0] r;
        r = '0;
        for (int i = TAG_W - 1; i >= 0; i--) begin
            r = {r[TW-1:0], tag[i]};
            if (r >= (TW+1)'(TAG_COUNT)) begin
                r = r - (TW+1)'(TAG_COUNT);
            end
        end
        return r[TW-1:0];
    endfunction

    logic [TAG_W-1:0]  s_tag;
    logic [TIME_W-1:0] s_now;
    logic [SEL_W-1:0]  s_sel;
    req_type_t         s_kind;
    logic [TW-1:0]     s_tag_idx;

    assign s_tag     = s_tdata[TAG_W-1:0];
    assign s_now     = s_tdata[TAG_W +: TIME_W];
    assign s_sel     = s_tdata[TAG_W+TIME_W +: SEL_W];
    assign s_kind    = req_type_t'(s_tuser);
    assign s_tag_idx = tag_index(s_tag);

    state_t             state_reg, state_next;
    logic [CW-1:0]      clr_cnt_reg, clr_cnt_next;
    req_type_t          kind_reg, kind_next;
    logic [TW-1:0]      tag_reg, tag_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [SEL_W-1:0]   sel_reg, sel_next;
    logic [BW-1:0]      bin_reg, bin_next;
    status_t            res_status_reg, res_status_next;
    logic [BIN_IDX_W-1:0] res_bin_reg, res_bin_next;
    logic [LAT_W-1:0]   res_lat_reg, res_lat_next;
    logic [CNT_W-1:0]   res_cnt_reg, res_cnt_next;
    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [BIN_IDX_W-1:0] m_bin_reg, m_bin_next;
    logic [LAT_W-1:0]   m_lat_reg, m_lat_next;
    logic [CNT_W-1:0]   m_cnt_reg, m_cnt_next;

    logic              tag_we, tag_re;
    logic [TW-1:0]     tag_waddr, tag_raddr;
    logic [TIME_W:0]   tag_wdata, tag_rdata;
    logic              hist_we, hist_re;
    logic [BW-1:0]     hist_waddr, hist_raddr;
    logic [CNT_W-1:0]  hist_wdata, hist_rdata, hist_inc;

    logic              div_start, div_done;
    logic [TIME_W-1:0] div_dividend;
    div_res_t          div_res;
    logic [BW-1:0]     bin_clamp;
    logic              sel_in_range;

    rlh_ram #(
        .WIDTH (TIME_W + 1),
        .DEPTH (TAG_COUNT)
    ) u_tag_ram (
        .clk   (aclk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (tag_re),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    rlh_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BIN_COUNT)
    ) u_hist_ram (
        .clk   (aclk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    rlh_udiv u_udiv (
        .clk      (aclk),
        .rst_n    (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .res      (div_res)
    );

    // clamp log2 to the last bin
    always_comb begin
        if ({1'b0, div_res.log2} > (LOG_W+1)'(BIN_COUNT - 1)) begin
            bin_clamp = BW'(BIN_COUNT - 1);
        end else begin
            bin_clamp = BW'(div_res.log2);
        end
    end

    assign sel_in_range = ((SEL_W+2)'(sel_reg) < (SEL_W+2)'(BIN_COUNT));
    assign hist_inc     = hist_rdata + 1'b1;
    assign s_tready     = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        kind_next       = kind_reg;
        tag_next        = tag_reg;
        now_next        = now_reg;
        sel_next        = sel_reg;
        bin_next        = bin_reg;
        res_status_next = res_status_reg;
        res_bin_next    = res_bin_reg;
        res_lat_next    = res_lat_reg;
        res_cnt_next    = res_cnt_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_bin_next      = m_bin_reg;
        m_lat_next      = m_lat_reg;
        m_cnt_next      = m_cnt_reg;
        tag_we          = 1'b0;
        tag_waddr       = tag_reg;
        tag_wdata       = '0;
        tag_re          = 1'b0;
        tag_raddr       = s_tag_idx;
        hist_we         = 1'b0;
        hist_waddr      = bin_reg;
        hist_wdata      = hist_inc;
        hist_re         = 1'b0;
        hist_raddr      = BW'(s_sel);
        div_start       = 1'b0;
        div_dividend    = now_reg - tag_rdata[TIME_W-1:0];

        case (state_reg)
            S_CLEAR: begin
                tag_we     = ({1'b0, clr_cnt_reg} < (CW+1)'(TAG_COUNT));
                tag_waddr  = clr_cnt_reg[TW-1:0];
                hist_we    = ({1'b0, clr_cnt_reg} < (CW+1)'(BIN_COUNT));
                hist_waddr = clr_cnt_reg[BW-1:0];
                hist_wdata = '0;
                if (clr_cnt_reg == CW'(CLR_N - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next    = s_kind;
                    tag_next     = s_tag_idx;
                    now_next     = s_now;
                    sel_next     = s_sel;
                    bin_next     = BW'(s_sel);
                    res_bin_next = '0;
                    res_lat_next = '0;
                    res_cnt_next = '0;
                    case (s_kind)
                        REQ_ISSUE: begin
                            tag_we          = 1'b1;
                            tag_waddr       = s_tag_idx;
                            tag_wdata       = {1'b1, s_now};
                            res_status_next = STATUS_ISSUED;
                            state_next      = S_OUT;
                        end
                        REQ_COMPLETE: begin
                            tag_re     = 1'b1;
                            state_next = S_TAG_WAIT;
                        end
                        REQ_READ: begin
                            hist_re         = 1'b1;
                            res_status_next = STATUS_READ;
                            res_bin_next    = s_sel;
                            state_next      = S_HIST_WAIT;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_TAG_WAIT: begin
                if (!tag_rdata[TIME_W]) begin
                    res_status_next = STATUS_IGNORED;
                    state_next      = S_OUT;
                end else begin
                    div_start  = 1'b1;
                    tag_we     = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    res_lat_next = div_res.quotient;
                    bin_next     = bin_clamp;
                    res_bin_next = BIN_IDX_W'(bin_clamp);
                    hist_re      = 1'b1;
                    hist_raddr   = bin_clamp;
                    state_next   = S_HIST_WAIT;
                end
            end
            S_HIST_WAIT: begin
                if (kind_reg == REQ_COMPLETE) begin
                    hist_we         = 1'b1;
                    res_cnt_next    = hist_inc;
                    res_status_next = STATUS_COUNTED;
                end else begin
                    res_cnt_next = sel_in_range ? hist_rdata : '0;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_bin_next    = res_bin_reg;
                    m_lat_next    = res_lat_reg;
                    m_cnt_next    = res_cnt_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        tag_reg        <= tag_next;
        now_reg        <= now_next;
        sel_reg        <= sel_next;
        bin_reg        <= bin_next;
        res_status_reg <= res_status_next;
        res_bin_reg    <= res_bin_next;
        res_lat_reg    <= res_lat_next;
        res_cnt_reg    <= res_cnt_next;
        m_status_reg   <= m_status_next;
        m_bin_reg      <= m_bin_next;
        m_lat_reg      <= m_lat_next;
        m_cnt_reg      <= m_cnt_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_cnt_reg, m_lat_reg, m_bin_reg};

    `RLH_ASSERT_NR(a_reset_clears, aclk, !aresetn |=> state_reg == S_CLEAR)
    `RLH_ASSERT(a_div_done_in_div, aclk, aresetn, div_done |-> state_reg == S_DIV)
    `RLH_ASSERT(a_counted_bin_range, aclk, aresetn,
        (m_valid_reg && m_status_reg == STATUS_COUNTED)
            |-> ((BIN_IDX_W+2)'(m_bin_reg) < (BIN_IDX_W+2)'(BIN_COUNT)))

endmodule

`default_nettype wire
